/* src/tes_pkg.sv */
// Shared constants, types and command/status structs for the timed event sequencer.
package tes_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int ACT_W       = 2;
  localparam int TIME_W      = 15;
  localparam int ID_W        = 8;
  localparam int WORD_W      = TIME_W + ID_W;
  localparam int ELAPSED_W   = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef struct packed {
    logic start;
    logic set_full;
    logic clear;
    logic restart;
    logic tick;
    logic rd_prev;
    logic shift;
    logic ins_new;
    logic rd_next;
    logic fire_take;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic i_zero;
    logic rd_later;
    logic rd_due;
    logic more;
    logic out_free;
    logic held_v;
  } stat_t;

endpackage

/* src/timed_event_sequencer_core.sv */
// Top level of the timed event sequencer: controller plus table datapath.
//
// Input channel: action, event_time and event_id with in_valid/in_stall.
// An item is taken when in_valid is high and in_stall is low. Actions are
// add, clear, restart and one-millisecond tick.
// Output channel: fired, fired_id, status and last with out_valid/out_stall.
// Every item gives one or more results; last marks the final one.
// Clear, restart and a dropped add go from idle straight to the final result.
// A stored add reads and compares each stored event with a later time and
// shifts it up one slot through the single table RAM, then writes the new
// event; when the new event lands in the first slot it is written with no
// further read. A tick scans the entries until one is not yet due or the
// table ends, since each entry is read from the RAM and compared one at a
// time; at most 16 events fire per tick. Each fired result of a tick is held
// back until the next entry has been checked, so last is known when shown.
// Reset empties the table, zeroes elapsed time and drops any pending result.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before producing the next one.
module timed_event_sequencer_core import tes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [TIME_W-1:0] event_time,
  input  logic [ID_W-1:0]   event_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              fired,
  output logic [ID_W-1:0]   fired_id,
  output logic              status,
  output logic              last
);

  cmd_t  cmd;
  stat_t stat;

  tes_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action  (action),
    .stat    (stat),
    .cmd     (cmd)
  );

  tes_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .event_time(event_time),
    .event_id  (event_id),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .fired     (fired),
    .fired_id  (fired_id),
    .status    (status),
    .last      (last)
  );

endmodule

/* src/tes_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tes_ctrl.sv */
// Controller state machine that sequences adds, clears, restarts and ticks.
module tes_ctrl import tes_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ACT_W-1:0] action,
  input  stat_t            stat,
  output cmd_t             cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ADD_RD   = 6'b000010,
    ST_ADD_CMP  = 6'b000100,
    ST_FIRE_RD  = 6'b001000,
    ST_FIRE_CMP = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (action)
            ACT_ADD: begin
              if (stat.full) begin
                cmd.set_full = 1'b1;
                state_next   = ST_EMIT;
              end else begin
                state_next = ST_ADD_RD;
              end
            end
            ACT_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = ST_EMIT;
            end
            ACT_RESTART: begin
              cmd.restart = 1'b1;
              state_next  = ST_EMIT;
            end
            ACT_TICK: begin
              cmd.tick   = 1'b1;
              state_next = ST_FIRE_RD;
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        if (stat.i_zero) begin
          cmd.ins_new = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (stat.rd_later) begin
          cmd.shift  = 1'b1;
          state_next = ST_ADD_RD;
        end else begin
          cmd.ins_new = 1'b1;
          state_next  = ST_EMIT;
        end
      end
      ST_FIRE_RD: begin
        if (stat.more) begin
          cmd.rd_next = 1'b1;
          state_next  = ST_FIRE_CMP;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_FIRE_CMP: begin
        if (stat.rd_due) begin
          if (!stat.held_v || stat.out_free) begin
            cmd.fire_take = 1'b1;
            state_next    = ST_FIRE_RD;
          end
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIRE_CMP) && stat.rd_due && stat.held_v && !stat.out_free
    |=> state == ST_FIRE_CMP)
    else $error("Fire stage left while the output register was busy.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |=> state == ST_IDLE)
    else $error("Final result did not return the sequencer to idle.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && in_valid && (action == ACT_TICK) |=> state == ST_FIRE_RD)
    else $error("Tick did not start the fire scan.");

endmodule

/* src/tes_dp.sv */
// Datapath holding the sorted event table, counters and the output register.
module tes_dp import tes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [TIME_W-1:0] event_time,
  input  logic [ID_W-1:0]   event_id,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              fired,
  output logic [ID_W-1:0]   fired_id,
  output logic              status,
  output logic              last
);

  logic [CNT_W-1:0]     slot_count;
  logic [CNT_W-1:0]     next_slot;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [CNT_W-1:0]     idx;
  logic [NRES_W-1:0]    n_fired;
  logic                 held_v;
  logic [ID_W-1:0]      held_id;
  logic                 status_r;
  logic [TIME_W-1:0]    ev_time;
  logic [ID_W-1:0]      ev_id;

  logic [CNT_W-1:0]     idx_m1;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    rd_word;
  logic [TIME_W-1:0]    rd_time;
  logic [ID_W-1:0]      rd_id;
  logic                 out_free;

  assign idx_m1    = idx - 1'b1;
  assign ram_we    = cmd.shift | cmd.ins_new;
  assign ram_waddr = idx[IDX_W-1:0];
  assign ram_wdata = cmd.shift ? rd_word : {ev_time, ev_id};
  assign ram_re    = cmd.rd_prev | cmd.rd_next;
  assign ram_raddr = cmd.rd_prev ? idx_m1[IDX_W-1:0] : next_slot[IDX_W-1:0];
  assign rd_time   = rd_word[WORD_W-1:ID_W];
  assign rd_id     = rd_word[ID_W-1:0];
  assign out_free  = !out_valid || !out_stall;

  tes_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_word)
  );

  always_comb begin
    stat.full     = (slot_count == CNT_W'(SLOTS));
    stat.i_zero   = (idx == '0);
    stat.rd_later = (rd_time > ev_time);
    stat.rd_due   = (ELAPSED_W'(rd_time) < elapsed_ms);
    stat.more     = (n_fired < NRES_W'(MAX_RESULTS)) && (next_slot < slot_count);
    stat.out_free = out_free;
    stat.held_v   = held_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      next_slot  <= '0;
      elapsed_ms <= '0;
      idx        <= '0;
      n_fired    <= '0;
      held_v     <= 1'b0;
      status_r   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx      <= slot_count;
        n_fired  <= '0;
        held_v   <= 1'b0;
        status_r <= cmd.set_full;
      end
      if (cmd.clear) begin
        slot_count <= '0;
        next_slot  <= '0;
      end
      if (cmd.restart) begin
        elapsed_ms <= '0;
        next_slot  <= '0;
      end
      if (cmd.tick && (elapsed_ms != '1)) begin
        elapsed_ms <= elapsed_ms + 1'b1;
      end
      if (cmd.shift) begin
        idx <= idx_m1;
      end
      if (cmd.ins_new) begin
        slot_count <= slot_count + 1'b1;
        if (idx < next_slot) begin
          next_slot <= next_slot + 1'b1;
        end
      end
      if (cmd.fire_take) begin
        held_v    <= 1'b1;
        next_slot <= next_slot + 1'b1;
        n_fired   <= n_fired + 1'b1;
      end
      if ((cmd.fire_take && held_v) || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ev_time <= event_time;
      ev_id   <= event_id;
    end
    if (cmd.fire_take) begin
      held_id <= rd_id;
    end
    if (cmd.fire_take && held_v) begin
      fired    <= 1'b1;
      fired_id <= held_id;
      status   <= 1'b0;
      last     <= 1'b0;
    end else if (cmd.emit_final) begin
      fired    <= held_v;
      fired_id <= held_v ? held_id : '0;
      status   <= status_r;
      last     <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) next_slot <= slot_count)
    else $error("Pending position ran past the end of the table.");

  assert property (@(posedge clk) disable iff (rst) slot_count <= CNT_W'(SLOTS))
    else $error("Event count exceeds the table size.");

  assert property (@(posedge clk) disable iff (rst) n_fired <= NRES_W'(MAX_RESULTS))
    else $error("Too many events fired in one tick.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.fire_take && held_v |-> out_free)
    else $error("Fired item overwrote a result still waiting at the output.");

endmodule
